[rtl/core/nbsl_pkg.sv]
// shared types, codes and defaults for the nearest-below symbol lookup
`default_nettype none
package nbsl_pkg;
   localparam int NUM_TABLES_DEF  = 4;
   localparam int TABLE_DEPTH_DEF = 256;

   localparam int OP_W    = 2;
   localparam int SLOT_W  = 2;
   localparam int ADDR_W  = 16;
   localparam int SYM_W   = 16;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 9;
   // wide enough for the largest table count and depth allowed
   localparam int TBL_W   = 4;
   localparam int FILL_W  = 13;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] table_slot;
      logic [ADDR_W-1:0] address;
      logic [SYM_W-1:0]  symbol_id;
   } cmd_type;

   typedef struct packed {
      logic              have;
      logic              span;
      logic [ADDR_W-1:0] addr;
      logic [SYM_W-1:0]  sym;
      logic [TBL_W-1:0]  tbl;
   } cand_type;

   typedef struct packed {
      logic              done;
      logic              full;
      logic [FILL_W-1:0] fill;
   } cell_stat_type;
endpackage
`default_nettype wire

[rtl/core/nbsl_req_if.sv]
// request and response channel interfaces
`default_nettype none
interface nbsl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [1:0]  table_slot;
   logic [15:0] address;
   logic [15:0] symbol_id;
   modport source (output valid, op, table_slot, address, symbol_id, input ready);
   modport sink   (input valid, op, table_slot, address, symbol_id, output ready);
endinterface

interface nbsl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [1:0]  hit_table;
   logic [15:0] hit_symbol;
   logic [15:0] offset;
   logic [8:0]  entry_count;
   modport source (output valid, status, hit_table, hit_symbol, offset, entry_count,
                   input ready);
   modport sink   (input valid, status, hit_table, hit_symbol, offset, entry_count,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/nbsl_ram.sv]
// generic single-write single-read ram with registered read
`default_nettype none
module nbsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[rtl/core/nbsl_cell.sv]
// one table cell: sorted storage, binary search, insert shift, best-candidate hand-off
`default_nettype none
module nbsl_cell import nbsl_pkg::*; #(
   parameter int IDX         = 0,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire cmd_type  cmd,
   input  wire cand_type prev,
   output cand_type      nxt,
   output cell_stat_type stat
);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int DW = ADDR_W + SYM_W;

   localparam logic [3:0] C_IDLE  = 4'd0;
   localparam logic [3:0] C_PROBE = 4'd1;
   localparam logic [3:0] C_CMP   = 4'd2;
   localparam logic [3:0] C_RDA   = 4'd3;
   localparam logic [3:0] C_RDF   = 4'd4;
   localparam logic [3:0] C_RDL   = 4'd5;
   localparam logic [3:0] C_FIN   = 4'd6;
   localparam logic [3:0] C_SRD   = 4'd7;
   localparam logic [3:0] C_SWR   = 4'd8;
   localparam logic [3:0] C_PUT   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic              in_use_ff, in_use_in;
   logic              full_ff, full_in;
   logic              look_ff, look_in;
   logic [CW-1:0]     lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [AW-1:0]     k_ff, k_in;
   logic [ADDR_W-1:0] ea_ff, ea_in, first_ff, first_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              have_ff, have_in, span_ff, span_in;
   cand_type          nxt_ff, nxt_in;

   logic              we;
   logic [AW-1:0]     waddr, raddr;
   logic [DW-1:0]     wdata, rdata;
   logic [CW-1:0]     mid;
   logic              target;
   logic [ADDR_W-1:0] rd_addr;

   assign target  = (int'(cmd.table_slot) == IDX);
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_addr = rdata[DW-1:SYM_W];

   nbsl_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      in_use_in = in_use_ff;
      full_in   = full_ff;
      look_in   = look_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      k_in      = k_ff;
      ea_in     = ea_ff;
      first_in  = first_ff;
      sym_in    = sym_ff;
      have_in   = have_ff;
      span_in   = span_ff;
      we        = 1'b0;
      waddr     = k_ff;
      wdata     = {cmd.address, cmd.symbol_id};
      raddr     = mid[AW-1:0];
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               if (cmd.op == OP_LOOKUP) begin
                  have_in = 1'b0;
                  look_in = 1'b1;
                  lo_in   = '0;
                  hi_in   = fill_ff;
                  if (in_use_ff && fill_ff != '0) begin
                     state_in = C_PROBE;
                  end
               end else if (cmd.op == OP_CLEAR && target) begin
                  fill_in   = '0;
                  in_use_in = 1'b1;
               end else if (cmd.op == OP_INSERT && target) begin
                  look_in = 1'b0;
                  lo_in   = '0;
                  hi_in   = fill_ff;
                  if (fill_ff == CW'(TABLE_DEPTH)) begin
                     full_in = 1'b1;
                  end else begin
                     full_in  = 1'b0;
                     state_in = C_PROBE;
                  end
               end
            end
         end
         C_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               state_in = C_CMP;
            end else if (!look_ff) begin
               k_in     = fill_ff[AW-1:0];
               state_in = (fill_ff > lo_ff) ? C_SRD : C_PUT;
            end else if (lo_ff == '0) begin
               state_in = C_IDLE;
            end else begin
               state_in = C_RDA;
            end
         end
         C_CMP: begin
            if (rd_addr <= cmd.address) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = C_PROBE;
         end
         C_RDA: begin
            raddr    = lo_ff[AW-1:0] - AW'(1);
            state_in = C_RDF;
         end
         C_RDF: begin
            raddr    = '0;
            ea_in    = rd_addr;
            sym_in   = rdata[SYM_W-1:0];
            state_in = C_RDL;
         end
         C_RDL: begin
            raddr    = fill_ff[AW-1:0] - AW'(1);
            first_in = rd_addr;
            state_in = C_FIN;
         end
         C_FIN: begin
            have_in  = 1'b1;
            span_in  = (cmd.address >= first_ff) && (cmd.address <= rd_addr);
            state_in = C_IDLE;
         end
         C_SRD: begin
            raddr    = k_ff - AW'(1);
            state_in = C_SWR;
         end
         C_SWR: begin
            we    = 1'b1;
            waddr = k_ff;
            wdata = rdata;
            k_in  = k_ff - AW'(1);
            state_in = ({{(CW-AW){1'b0}}, k_in} > lo_ff) ? C_SRD : C_PUT;
         end
         C_PUT: begin
            we       = 1'b1;
            waddr    = lo_ff[AW-1:0];
            fill_in  = fill_ff + CW'(1);
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   // keep the incoming best unless this table beats it
   always_comb begin
      nxt_in = prev;
      if (have_ff && (!prev.have || (span_ff && !prev.span) ||
                      (span_ff == prev.span && ea_ff > prev.addr))) begin
         nxt_in.have = 1'b1;
         nxt_in.span = span_ff;
         nxt_in.addr = ea_ff;
         nxt_in.sym  = sym_ff;
         nxt_in.tbl  = TBL_W'(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= C_IDLE;
         fill_ff   <= '0;
         in_use_ff <= 1'b0;
         have_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         in_use_ff <= in_use_in;
         have_ff   <= have_in;
      end
      full_ff  <= full_in;
      look_ff  <= look_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      k_ff     <= k_in;
      ea_ff    <= ea_in;
      first_ff <= first_in;
      sym_ff   <= sym_in;
      span_ff  <= span_in;
      nxt_ff   <= nxt_in;
   end

   assign nxt       = nxt_ff;
   assign stat.done = (state_ff == C_IDLE);
   assign stat.full = full_ff;
   assign stat.fill = FILL_W'(fill_ff);
endmodule
`default_nettype wire

[rtl/core/nearest_below_symbol_lookup.sv]
// top level: command sequencer over a row of table cells
//
//  channel | dir | payload                                          | handshake
//  req_bus | in  | op, table_slot, address, symbol_id               | valid/ready
//  rsp_bus | out | status, hit_table, hit_symbol, offset, entry_count | valid/ready
//
// one beat at a time
// lookup: every cell binary-searches its own table ram in parallel, a probe and
//   a compare per step, then reads the hit, first and last entries; the best
//   candidate then ripples one cell per cycle
// insert: search, then a read and a write per shifted entry in the table ram
// synchronous reset clears fills and in-use flags; table rams need no clearing
// a stalled response holds in its register; a new request is still taken, but its response waits until it is free
`default_nettype none
module nearest_below_symbol_lookup import nbsl_pkg::*; #(
   parameter int NUM_TABLES  = NUM_TABLES_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   nbsl_req_if.sink   req_bus,
   nbsl_rsp_if.source rsp_bus
);
   localparam int NW = $clog2(NUM_TABLES + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LAUNCH = 3'd1;
   localparam logic [2:0] S_RUN    = 3'd2;
   localparam logic [2:0] S_CHAIN  = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   cmd_type       cmd_ff, cmd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [SLOT_W-1:0]  table_ff, table_in;
   logic [SYM_W-1:0]   symbol_ff, symbol_in;
   logic [ADDR_W-1:0]  offset_ff, offset_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   cand_type      chain [NUM_TABLES+1];
   cell_stat_type stat [NUM_TABLES];
   logic          all_done;
   logic          slot_ok;
   cell_stat_type sel;

   assign chain[0] = '0;

   // one cell per table, best candidate handed down the row
   for (genvar i = 0; i < NUM_TABLES; i++) begin : g_cell
      nbsl_cell #(.IDX(i), .TABLE_DEPTH(TABLE_DEPTH)) u_cell (
         .clock(clock), .reset(reset), .start(state_ff == S_LAUNCH),
         .cmd(cmd_ff), .prev(chain[i]), .nxt(chain[i+1]), .stat(stat[i])
      );
   end

   always_comb begin
      all_done = 1'b1;
      slot_ok  = 1'b0;
      sel      = '0;
      for (int i = 0; i < NUM_TABLES; i++) begin
         all_done = all_done & stat[i].done;
         if (int'(cmd_ff.table_slot) == i) begin
            slot_ok = 1'b1;
            sel     = stat[i];
         end
      end
   end

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      table_in     = table_ff;
      symbol_in    = symbol_ff;
      offset_in    = offset_ff;
      count_in     = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in.op         = req_bus.op;
               cmd_in.table_slot = req_bus.table_slot;
               cmd_in.address    = req_bus.address;
               cmd_in.symbol_id  = req_bus.symbol_id;
               state_in          = S_LAUNCH;
            end
         end
         S_LAUNCH: state_in = S_RUN;
         S_RUN: begin
            if (all_done) begin
               cnt_in   = '0;
               state_in = S_CHAIN;
            end
         end
         S_CHAIN: begin
            // let the best candidate ripple through every cell
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(NUM_TABLES)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_DONE;
               table_in     = cmd_ff.table_slot;
               symbol_in    = '0;
               offset_in    = '0;
               count_in     = '0;
               if (cmd_ff.op == OP_LOOKUP) begin
                  if (chain[NUM_TABLES].have) begin
                     status_in = ST_FOUND;
                     table_in  = chain[NUM_TABLES].tbl[SLOT_W-1:0];
                     symbol_in = chain[NUM_TABLES].sym;
                     offset_in = cmd_ff.address - chain[NUM_TABLES].addr;
                  end else begin
                     status_in = ST_MISS;
                     table_in  = '0;
                  end
               end else if (cmd_ff.op == OP_INSERT && slot_ok) begin
                  status_in = sel.full ? ST_FULL : ST_DONE;
                  count_in  = sel.fill[COUNT_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff    <= cnt_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      table_ff  <= table_in;
      symbol_ff <= symbol_in;
      offset_ff <= offset_in;
      count_ff  <= count_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.hit_table   = table_ff;
   assign rsp_bus.hit_symbol  = symbol_ff;
   assign rsp_bus.offset      = offset_ff;
   assign rsp_bus.entry_count = count_ff;
endmodule
`default_nettype wire
